// File: src/dct_pkg.sv
// Shared types, codes and the microcode program of the display contention timing block.
package dct_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FRAME_TSTATES  = 3'd0,
    CFG_LINE_TSTATES   = 3'd1,
    CFG_ORIGIN_TSTATES = 3'd2,
    CFG_ACTIVE_LINES   = 3'd3,
    CFG_DELAY_PATTERN  = 3'd4,
    CFG_MACHINE_MODEL  = 3'd5
  } cfg_index_t;

  // Request kinds
  localparam logic REQ_MEM = 1'b0;
  localparam logic REQ_IO  = 1'b1;

  // Address decode constants
  localparam logic [15:0] AREA_MASK    = 16'hC000;
  localparam logic [15:0] AREA_MATCH   = 16'h4000;
  localparam logic [15:0] PORT_ODD_BIT = 16'h0001;
  localparam logic [10:0] ACTIVE_COLS  = 11'd128;

  // Reset values of the configuration registers
  localparam logic [16:0] FRAME_RST   = 17'd69888;
  localparam logic [9:0]  LINE_RST    = 10'd224;
  localparam logic [16:0] ORIGIN_RST  = 17'd14335;
  localparam logic [9:0]  ACTIVE_RST  = 10'd192;
  localparam logic [31:0] PATTERN_RST = 32'h0012_3456;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MOD,
    ST_POS,
    ST_LINE,
    ST_APPLY,
    ST_DONE
  } state_t;

  // Micro-operation kinds
  typedef enum logic {
    UOP_DISPATCH,
    UOP_STEP
  } uop_kind_t;

  // One control word
  typedef struct packed {
    uop_kind_t  kind;
    logic       contend;  // add lookup delay before base cycles
    logic [2:0] base;     // base t-states added
    logic       last;     // final step of the sequence
  } uop_t;

  typedef logic [3:0] upc_t;

  // Program entry points
  localparam upc_t ENTRY_MEM     = 4'd1;
  localparam upc_t ENTRY_C_EVEN  = 4'd2;
  localparam upc_t ENTRY_C_ODD   = 4'd4;
  localparam upc_t ENTRY_N_EVEN  = 4'd8;
  localparam upc_t ENTRY_N_ODD   = 4'd10;
  localparam upc_t UPC_LAST      = 4'd10;

  // Microcode program: dispatch step, memory query, then the four IO sequences
  function automatic uop_t dct_rom(input upc_t addr);
    uop_t w;
    w = '{kind: UOP_STEP, contend: 1'b0, base: 3'd0, last: 1'b1};
    unique case (addr)
      4'd0:    w = '{kind: UOP_DISPATCH, contend: 1'b0, base: 3'd0, last: 1'b0};
      4'd1:    w = '{kind: UOP_STEP, contend: 1'b1, base: 3'd0, last: 1'b1};
      4'd2:    w = '{kind: UOP_STEP, contend: 1'b1, base: 3'd1, last: 1'b0};
      4'd3:    w = '{kind: UOP_STEP, contend: 1'b1, base: 3'd3, last: 1'b1};
      4'd4:    w = '{kind: UOP_STEP, contend: 1'b1, base: 3'd1, last: 1'b0};
      4'd5:    w = '{kind: UOP_STEP, contend: 1'b1, base: 3'd1, last: 1'b0};
      4'd6:    w = '{kind: UOP_STEP, contend: 1'b1, base: 3'd1, last: 1'b0};
      4'd7:    w = '{kind: UOP_STEP, contend: 1'b1, base: 3'd1, last: 1'b1};
      4'd8:    w = '{kind: UOP_STEP, contend: 1'b0, base: 3'd1, last: 1'b0};
      4'd9:    w = '{kind: UOP_STEP, contend: 1'b1, base: 3'd3, last: 1'b1};
      4'd10:   w = '{kind: UOP_STEP, contend: 1'b0, base: 3'd4, last: 1'b1};
      default: w = '{kind: UOP_STEP, contend: 1'b0, base: 3'd0, last: 1'b1};
    endcase
    return w;
  endfunction

  // Dispatch target from request kind, address area and port parity
  function automatic upc_t dct_entry(input logic req, input logic area, input logic even);
    upc_t e;
    if (req == REQ_MEM) begin
      e = ENTRY_MEM;
    end else if (area) begin
      e = even ? ENTRY_C_EVEN : ENTRY_C_ODD;
    end else begin
      e = even ? ENTRY_N_EVEN : ENTRY_N_ODD;
    end
    return e;
  endfunction

endpackage

// File: src/display_contention_timing.sv
// Top level of the display contention timing block: sequencer, divider and output register.
//
// Each input word is one access; the block returns one result word with the total display
// contention delay, the end t-state and the area flag. A microcoded sequencer walks a short
// program per access (one lookup for a memory query, up to four for an IO access). Each lookup
// runs a shared one-bit-per-cycle divider up to twice: once for t-state modulo frame length,
// skipped when frame length is zero, and once for the line/column split, skipped before the
// origin or with zero line length; a step without contention is retired without a lookup.
// One item is in work at a time; a finished result waits in the output register while the next
// word is accepted, and the finishing step stalls while the previous result is still held.
// Configuration words are taken in every cycle and must be written while idle.
module display_contention_timing
  import dct_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] address, [47:16] start_tstate
  input  logic        in_tuser,   // [0] req_type
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [5:0] delay_total, [37:6] end_tstate, [39:38] zero
  output logic        out_tuser,  // [0] contended_area
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers
  logic [16:0] frame_r;
  logic [9:0]  line_r;
  logic [16:0] origin_r;
  logic [9:0]  active_r;
  logic [31:0] pattern_r;

  // Sequencer and datapath registers
  state_t      state_r, state_nxt;
  upc_t        upc_r, upc_nxt;
  logic [31:0] t_r, t_nxt;
  logic [5:0]  sum_r, sum_nxt;
  logic        req_r, area_r, even_r;
  logic [31:0] div_q_r, div_q_nxt;
  logic [16:0] div_rem_r, div_rem_nxt;
  logic [4:0]  div_cnt_r, div_cnt_nxt;

  // Output register
  logic        out_valid_r;
  logic [5:0]  out_delay_r;
  logic [31:0] out_end_r;
  logic        out_area_r;

  uop_t        uop;
  logic        in_acc;
  logic        out_load;
  logic        apply_en;
  logic [3:0]  apply_delay;
  logic [16:0] divisor;
  logic [17:0] div_trial;
  logic [17:0] div_diff;
  logic [31:0] pos;
  logic        pos_hit;
  logic [9:0]  col;
  logic        col_hit;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign uop        = dct_rom(upc_r);

  // Configuration writes; out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r   <= FRAME_RST;
      line_r    <= LINE_RST;
      origin_r  <= ORIGIN_RST;
      active_r  <= ACTIVE_RST;
      pattern_r <= PATTERN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_TSTATES:  frame_r   <= cfg_data[16:0];
        CFG_LINE_TSTATES:   line_r    <= cfg_data[9:0];
        CFG_ORIGIN_TSTATES: origin_r  <= cfg_data[16:0];
        CFG_ACTIVE_LINES:   active_r  <= cfg_data[9:0];
        CFG_DELAY_PATTERN:  pattern_r <= cfg_data;
        CFG_MACHINE_MODEL:  ; // both models decode alike: nothing to hold
        default:            ;
      endcase
    end
  end

  // Divider step: shift one dividend bit into the remainder, subtract if it fits
  assign divisor   = (state_r == ST_MOD) ? frame_r : {7'd0, line_r};
  assign div_trial = {div_rem_r, div_q_r[31]};
  assign div_diff  = div_trial - {1'b0, divisor};

  // Frame position: remainder of the first division, or the raw t-state with no frame length
  assign pos     = (frame_r == '0) ? t_r : {15'd0, div_rem_r};
  assign pos_hit = (pos >= {15'd0, origin_r}) && (line_r != '0);

  // Line and column after the second division
  assign col     = div_rem_r[9:0];
  assign col_hit = (div_q_r < {22'd0, active_r}) && ({1'b0, col} < ACTIVE_COLS);

  // Next state and datapath control
  always_comb begin
    state_nxt   = state_r;
    upc_nxt     = upc_r;
    t_nxt       = t_r;
    sum_nxt     = sum_r;
    div_q_nxt   = div_q_r;
    div_rem_nxt = div_rem_r;
    div_cnt_nxt = div_cnt_r;
    apply_en    = 1'b0;
    apply_delay = 4'd0;
    out_load    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          t_nxt     = in_tdata[47:16];
          sum_nxt   = 6'd0;
          upc_nxt   = '0;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (uop.kind == UOP_DISPATCH) begin
          upc_nxt = dct_entry(req_r, area_r, even_r);
        end else if (!uop.contend) begin
          apply_en = 1'b1;
        end else if (frame_r != '0) begin
          // start t-state modulo frame length
          div_q_nxt   = t_r;
          div_rem_nxt = '0;
          div_cnt_nxt = '1;
          state_nxt   = ST_MOD;
        end else begin
          state_nxt = ST_POS;
        end
      end
      ST_MOD, ST_LINE: begin
        if (div_diff[17]) begin
          div_rem_nxt = div_trial[16:0];
          div_q_nxt   = {div_q_r[30:0], 1'b0};
        end else begin
          div_rem_nxt = div_diff[16:0];
          div_q_nxt   = {div_q_r[30:0], 1'b1};
        end
        div_cnt_nxt = div_cnt_r - 5'd1;
        if (div_cnt_r == '0) begin
          state_nxt = (state_r == ST_MOD) ? ST_POS : ST_APPLY;
        end
      end
      ST_POS: begin
        if (pos_hit) begin
          // split offset from origin into line and column
          div_q_nxt   = pos - {15'd0, origin_r};
          div_rem_nxt = '0;
          div_cnt_nxt = '1;
          state_nxt   = ST_LINE;
        end else begin
          apply_en = 1'b1;
        end
      end
      ST_APPLY: begin
        apply_en    = 1'b1;
        apply_delay = col_hit ? pattern_r[{col[2:0], 2'b00} +: 4] : 4'd0;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Retire the current step: add delay and base cycles, then advance the program or finish
    if (apply_en) begin
      t_nxt   = t_r + 32'(apply_delay) + 32'(uop.base);
      sum_nxt = sum_r + 6'(apply_delay);
      if (uop.last) begin
        state_nxt = ST_DONE;
      end else begin
        upc_nxt   = upc_r + 4'd1;
        state_nxt = ST_EXEC;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath and captured request fields
  always_ff @(posedge clk) begin
    upc_r     <= upc_nxt;
    t_r       <= t_nxt;
    sum_r     <= sum_nxt;
    div_q_r   <= div_q_nxt;
    div_rem_r <= div_rem_nxt;
    div_cnt_r <= div_cnt_nxt;
    if (in_acc) begin
      req_r  <= in_tuser;
      area_r <= (in_tdata[15:0] & AREA_MASK) == AREA_MATCH;
      even_r <= (in_tdata[15:0] & PORT_ODD_BIT) == 16'd0;
    end
    if (out_load) begin
      out_delay_r <= sum_r;
      out_end_r   <= t_r;
      out_area_r  <= area_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_end_r, out_delay_r};
  assign out_tuser  = out_area_r;

  // Program counter stays inside the program while an item is in work
  a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (upc_r <= UPC_LAST))
    else $error("microcode step counter beyond program");

  // Divisions only run against a nonzero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_MOD) |-> (frame_r != '0)) and ((state_r == ST_LINE) |-> (line_r != '0)))
    else $error("divider running with zero divisor");

  // Accepted word starts the program at its dispatch step
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ((state_r == ST_EXEC) && (upc_r == '0) && (sum_r == 6'd0)))
    else $error("accepted word did not start at dispatch");

  // Delay sum never exceeds four lookups of the largest entry
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_delay_r <= 6'd60))
    else $error("delay total out of range");

  // A result loads only from the finishing state
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == ST_DONE))
    else $error("result loaded outside the finishing state");

endmodule
